@@ rtl/core/rqc_pkg.sv @@
// Shared types and constants of the rolling q-gram coder.
`timescale 1ns / 1ps
`default_nettype none
package rqc_pkg;

  localparam int SYMBOL_W   = 8;
  localparam int CODE_W     = 64;
  localparam int ALPHABET_W = 9;
  localparam int GRAM_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ALPHABET_W;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GRAM_LENGTH = CFG_IDX_W'(1);

  localparam logic [ALPHABET_W-1:0] ALPHABET_RESET = ALPHABET_W'(4);
  localparam logic [GRAM_W-1:0]     GRAM_RESET     = GRAM_W'(8);

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/rqc_if.sv @@
// Valid/ready channels for symbol items and code items.
`timescale 1ns / 1ps
`default_nettype none
interface rqc_sym_if;
  import rqc_pkg::*;
  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;
  logic                last_symbol;
  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

interface rqc_code_if;
  import rqc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code;
  logic              sequence_end;
  modport source (output valid, output code, output sequence_end, input ready);
  modport sink   (input valid, input code, input sequence_end, output ready);
endinterface
`default_nettype wire

@@ rtl/core/rqc_ring.sv @@
// Symbol ring memory: one write port, one registered read port, read-first.
`timescale 1ns / 1ps
`default_nettype none
module rqc_ring #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [rqc_pkg::SYMBOL_W-1:0] wdata,
  input  wire logic                         re,
  input  wire logic [AW-1:0]                raddr,
  output logic      [rqc_pkg::SYMBOL_W-1:0] rdata
);
  import rqc_pkg::*;

  // no reset: an entry is only read after the current sequence has written it
  logic [SYMBOL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/rolling_qgram_coder_top.sv @@
// Rolling q-gram coder: base-alphabet integer code of every window of a symbol stream.
`timescale 1ns / 1ps
`default_nettype none
// Each symbol item is accepted in ST_IDLE and then worked in ST_CALC: on accept the ring memory is
// read at the oldest window slot and the running code is multiplied by the
// radix; in ST_CALC one shared 64x9 multiplier either advances the
// power radix^fill or forms oldest*radix^q, which is subtracted to give the
// new code. ST_CALC is held while the output register still holds a code
// that has not been taken and the item has a code to emit; no new symbol
// item is taken until the last one has left ST_CALC. Codes wrap modulo 2^64.
// The window ring needs no clearing pass after reset; a last_symbol item or a
// configuration write to the radix or gram length restarts the sequence.
module rolling_qgram_coder_top #(
  parameter int MAX_GRAM_LENGTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [rqc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rqc_pkg::CFG_DATA_W-1:0] cfg_data,
  rqc_sym_if.sink                             sym_ch,
  rqc_code_if.source                          code_ch
);
  import rqc_pkg::*;

  localparam int AW = (MAX_GRAM_LENGTH > 1) ? $clog2(MAX_GRAM_LENGTH) : 1;
  localparam int QW = $clog2(MAX_GRAM_LENGTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_GRAM_LENGTH - 1);
  localparam logic [QW:0]   DEPTH_EXT = (QW+1)'(MAX_GRAM_LENGTH);

  state_t state, state_next;

  logic [ALPHABET_W-1:0] radix;
  logic [GRAM_W-1:0]     gram_length;

  logic [AW-1:0]         wp;
  logic [QW-1:0]         fill_count;
  logic [CODE_W-1:0]     running_code;
  logic [CODE_W-1:0]     power;       // radix^fill_count
  logic [CODE_W-1:0]     code_scaled; // running_code * radix
  logic [SYMBOL_W-1:0]   sym;
  logic                  last;
  logic                  filling;

  logic                  out_valid;
  logic [CODE_W-1:0]     out_code;
  logic                  out_end;

  logic [QW-1:0]         q_eff;
  logic [QW:0]           wp_ext;
  logic [QW:0]           q_ext;
  logic [AW-1:0]         old_addr;
  logic [SYMBOL_W-1:0]   old_sym;
  logic                  accept;
  logic                  cfg_hit;
  logic                  emit;
  logic                  advance;
  logic                  out_free;
  logic [ALPHABET_W-1:0] mul_op;
  logic [CODE_W-1:0]     product;
  logic [CODE_W-1:0]     code_next;
  logic [QW:0]           fill_inc;

  // window length clamped to 1..MAX_GRAM_LENGTH
  always_comb begin
    if (gram_length == '0) begin
      q_eff = QW'(1);
    end else if (32'(gram_length) > 32'(MAX_GRAM_LENGTH)) begin
      q_eff = QW'(MAX_GRAM_LENGTH);
    end else begin
      q_eff = QW'(gram_length);
    end
  end

  assign wp_ext = (QW+1)'(wp);
  assign q_ext  = (QW+1)'(q_eff);

  always_comb begin
    if (wp_ext >= q_ext) begin
      old_addr = AW'(wp_ext - q_ext);
    end else begin
      old_addr = AW'(wp_ext + DEPTH_EXT - q_ext);
    end
  end

  assign accept  = sym_ch.valid && sym_ch.ready;
  assign cfg_hit = cfg_we && (cfg_index == CFG_RADIX || cfg_index == CFG_GRAM_LENGTH);

  rqc_ring #(
    .DEPTH (MAX_GRAM_LENGTH),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata (sym_ch.symbol),
    .re    (accept),
    .raddr (old_addr),
    .rdata (old_sym)
  );

  // shared multiplier: weight update while filling, oldest-symbol term when sliding
  assign mul_op   = filling ? radix : ALPHABET_W'(old_sym);
  assign product  = power * CODE_W'(mul_op);
  assign fill_inc = (QW+1)'(fill_count) + (QW+1)'(1);

  always_comb begin
    if (filling) begin
      code_next = code_scaled + CODE_W'(sym);
      emit      = (fill_inc == q_ext);
    end else begin
      code_next = code_scaled - product + CODE_W'(sym);
      emit      = 1'b1;
    end
  end

  assign out_free = !out_valid || code_ch.ready;

  always_comb begin
    state_next   = state;
    sym_ch.ready = 1'b0;
    advance      = 1'b0;
    case (state)
      ST_IDLE: begin
        sym_ch.ready = 1'b1;
        if (sym_ch.valid) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (!emit || out_free) begin
          advance    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= ALPHABET_RESET;
      gram_length <= GRAM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIX:       radix       <= cfg_data;
        CFG_GRAM_LENGTH: gram_length <= cfg_data[GRAM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      wp           <= '0;
      fill_count   <= '0;
      running_code <= '0;
      power        <= CODE_W'(1);
    end else if (accept) begin
      wp          <= (wp == LAST_SLOT) ? '0 : wp + AW'(1);
      code_scaled <= running_code * CODE_W'(radix);
      sym         <= sym_ch.symbol;
      last        <= sym_ch.last_symbol;
      filling     <= (fill_count < q_eff);
    end else if (advance) begin
      if (last) begin
        wp           <= '0;
        fill_count   <= '0;
        running_code <= '0;
        power        <= CODE_W'(1);
      end else begin
        running_code <= code_next;
        if (filling) begin
          fill_count <= QW'(fill_inc);
          power      <= product;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (code_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_code <= code_next;
      out_end  <= last;
    end
  end

  assign code_ch.valid        = out_valid;
  assign code_ch.code         = out_code;
  assign code_ch.sequence_end = out_end;

endmodule
`default_nettype wire

@@ rtl/core/rqc_checker.sv @@
// Port-level checks of the rolling q-gram coder and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rqc_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [rqc_pkg::CODE_W-1:0]   out_code,
  input wire logic                         out_end
);
  import rqc_pkg::*;

  logic in_accept;
  assign in_accept = in_valid && in_ready;

  // a stalled code item holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_code) && $stable(out_end))
    else $error("code item changed while stalled");

  // one symbol item in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !in_ready)
    else $error("symbol item accepted while one is in flight");

  // a fresh code item only appears after an accepted symbol item
  a_out_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_accept, 2))
    else $error("code item without a matching symbol item");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("code item valid right after reset");

endmodule

bind rolling_qgram_coder_top rqc_checker u_rqc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sym_ch.valid),
  .in_ready  (sym_ch.ready),
  .out_valid (code_ch.valid),
  .out_ready (code_ch.ready),
  .out_code  (code_ch.code),
  .out_end   (code_ch.sequence_end)
);
`default_nettype wire
